// ----- rtl/qsm_pkg.sv -----
// Shared constants, step table and register indexes of the quant step mapper.
`default_nettype none

package qsm_pkg;

    localparam int QF_W      = 8;
    localparam int HINT_W    = 4;
    localparam int STEP_W    = 16;
    localparam int MIN_W     = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int TABLE_STEPS = 32;
    localparam int FRAC_BITS   = 4;
    localparam int FRAC_STEPS  = 1 << FRAC_BITS;
    localparam int POS_W       = 10;
    localparam int IDX_W       = 6;
    localparam int SCALE_W     = 16;

    localparam int LANES  = 3;
    localparam int LANE_Y = 0;
    localparam int LANE_U = 1;
    localparam int LANE_V = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_U_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 3'd4;

    localparam logic [MIN_W-1:0]  MIN_STEP_RESET = 10'd128;
    localparam logic [STEP_W-1:0] MAX_STEP_RESET = 16'd8192;

    localparam logic [STEP_W-1:0] MID_STEPS [TABLE_STEPS-1] = '{
        16'd592,  16'd637,  16'd685,  16'd738,  16'd794,  16'd855,  16'd920,  16'd991,
        16'd1066, 16'd1148, 16'd1236, 16'd1330, 16'd1432, 16'd1541, 16'd1659, 16'd1786,
        16'd1922, 16'd2069, 16'd2227, 16'd2397, 16'd2580, 16'd2777, 16'd2990, 16'd3218,
        16'd3464, 16'd3729, 16'd4013, 16'd4320, 16'd4650, 16'd5005, 16'd5388
    };

endpackage

`default_nettype wire

// ----- rtl/qsm_if.sv -----
// Valid/ready channel interfaces for quality requests and step results.
`default_nettype none

interface qsm_req_if;
    logic                      valid;
    logic                      ready;
    logic [qsm_pkg::QF_W-1:0]   q_factor;
    logic [qsm_pkg::HINT_W-1:0] q_hint;

    modport source (output valid, q_factor, q_hint, input ready);
    modport sink   (input valid, q_factor, q_hint, output ready);
endinterface

interface qsm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [qsm_pkg::STEP_W-1:0] luma_step;
    logic [qsm_pkg::STEP_W-1:0] u_dc_step;
    logic [qsm_pkg::STEP_W-1:0] u_ac_step;
    logic [qsm_pkg::STEP_W-1:0] v_dc_step;
    logic [qsm_pkg::STEP_W-1:0] v_ac_step;
    logic [qsm_pkg::STEP_W-1:0] alpha_step;

    modport source (output valid, luma_step, u_dc_step, u_ac_step, v_dc_step, v_ac_step,
                    alpha_step, input ready);
    modport sink   (input valid, luma_step, u_dc_step, u_ac_step, v_dc_step, v_ac_step,
                    alpha_step, output ready);
endinterface

`default_nettype wire

// ----- rtl/quality_to_quant_step_mapper_core.sv -----
// Quality factor to quantizer step mapper, six-stage pipeline.
//
// Channels: req carries q_factor and q_hint, rsp carries the six quantizer
// steps of one segment (luma, U DC/AC, V DC/AC, alpha). A beat moves on a
// channel when valid and ready are both high. The user must write config registers
// via cfg_we / cfg_index / cfg_data while no request is in flight; not enforced.
//
// Throughput: one beat per cycle while rsp.ready is high; each stage holds one
// request, stages are saturate/offset, position table, step table,
// interpolation, DC scaling multiply and round/clamp.
//
// Reset: all stage valid bits clear and the config registers return to their
// defaults (offsets zero, min step 128, max step 8192).
// Stall: while rsp.ready is low the output beat holds; earlier stages keep
// filling until every stage is occupied, then req.ready drops. No beat is
// lost or repeated.
`default_nettype none

module quality_to_quant_step_mapper_core #(
    parameter int QFACTOR_MAX = 64,
    parameter int HINT_MAX    = 15
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    qsm_req_if.sink                              req,
    qsm_rsp_if.source                            rsp,
    input  wire logic                            cfg_we,
    input  wire logic [qsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [qsm_pkg::CFG_W-1:0]       cfg_data
);
    import qsm_pkg::*;

    localparam int QW     = $clog2(QFACTOR_MAX + 1);
    localparam int HW     = $clog2(HINT_MAX + 1);
    localparam int STAGES = 6;

    // config registers
    logic [QF_W-1:0]   u_offset_mult_reg;
    logic [QF_W-1:0]   v_offset_mult_reg;
    logic [QF_W-1:0]   neutral_mult_reg;
    logic [MIN_W-1:0]  min_step_reg;
    logic [STEP_W-1:0] max_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_offset_mult_reg <= '0;
            v_offset_mult_reg <= '0;
            neutral_mult_reg  <= '0;
            min_step_reg      <= MIN_STEP_RESET;
            max_step_reg      <= MAX_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_U_OFFSET: u_offset_mult_reg <= cfg_data[QF_W-1:0];
                CFG_V_OFFSET: v_offset_mult_reg <= cfg_data[QF_W-1:0];
                CFG_NEUTRAL:  neutral_mult_reg  <= cfg_data[QF_W-1:0];
                CFG_MIN_STEP: min_step_reg      <= cfg_data[MIN_W-1:0];
                CFG_MAX_STEP: max_step_reg      <= cfg_data[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // constant tables
    logic [POS_W-1:0]   pos_lut   [QFACTOR_MAX+1];
    logic [SCALE_W-1:0] scale_lut [HINT_MAX+1];

    for (genvar gi = 0; gi <= QFACTOR_MAX; gi++)
    begin : g_pos
        localparam int POS = (gi * TABLE_STEPS * FRAC_STEPS) / QFACTOR_MAX;
        assign pos_lut[gi] = POS_W'(POS);
    end

    for (genvar gi = 0; gi <= HINT_MAX; gi++)
    begin : g_scale
        localparam longint SC =
            (64'd65536 * (15 * HINT_MAX + 55 * gi) + 50 * HINT_MAX) / (100 * HINT_MAX);
        assign scale_lut[gi] = SCALE_W'(SC);
    end

    function automatic logic [STEP_W-1:0] table_at(
        input logic [IDX_W-1:0]  idx,
        input logic [MIN_W-1:0]  lo,
        input logic [STEP_W-1:0] hi
    );
        logic [STEP_W-1:0] r;
        if (idx == '0)
            r = STEP_W'(lo);
        else if (idx >= IDX_W'(TABLE_STEPS))
            r = hi;
        else
            r = MID_STEPS[5'(idx - IDX_W'(1))];
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] clamp_step(
        input logic [STEP_W:0]   q,
        input logic [MIN_W-1:0]  lo,
        input logic [STEP_W-1:0] hi
    );
        logic [STEP_W:0] r;
        r = q;
        if (r > {1'b0, hi})
            r = {1'b0, hi};
        if (r < (STEP_W+1)'(lo))
            r = (STEP_W+1)'(lo);
        return r[STEP_W-1:0];
    endfunction

    // handshake chain
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] stage_en;
    logic [STAGES:1] valid_next;

    always_comb
    begin
        stage_en[STAGES] = ~valid_reg[STAGES] | rsp.ready;
        for (int k = STAGES - 1; k >= 1; k--)
            stage_en[k] = ~valid_reg[k] | stage_en[k+1];
        valid_next[1] = req.valid;
        for (int k = 2; k <= STAGES; k++)
            valid_next[k] = valid_reg[k-1];
    end

    assign req.ready = stage_en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 1; k <= STAGES; k++)
                if (stage_en[k])
                    valid_reg[k] <= valid_next[k];
        end
    end

    // stage 1: saturate, chroma offset, clamp
    logic [QW-1:0] q1_reg  [LANES];
    logic [QW-1:0] q1_next [LANES];
    logic [HW-1:0] h1_reg;
    logic [HW-1:0] h1_next;
    logic [QF_W-1:0] qf_sat;
    logic [9:0]      qu_sum;
    logic [9:0]      qv_sum;

    always_comb
    begin
        qf_sat = (req.q_factor > QF_W'(QFACTOR_MAX)) ? QF_W'(QFACTOR_MAX)
                                                     : req.q_factor;
        h1_next = (req.q_hint > HINT_W'(HINT_MAX)) ? HW'(HINT_MAX)
                                                   : req.q_hint[HW-1:0];
        qu_sum = 10'(qf_sat) + 10'(u_offset_mult_reg) - 10'(neutral_mult_reg);
        qv_sum = 10'(qf_sat) + 10'(v_offset_mult_reg) - 10'(neutral_mult_reg);
        q1_next[LANE_Y] = qf_sat[QW-1:0];
        if (qu_sum[9])
            q1_next[LANE_U] = '0;
        else if (qu_sum[8:0] > 9'(QFACTOR_MAX))
            q1_next[LANE_U] = QW'(QFACTOR_MAX);
        else
            q1_next[LANE_U] = qu_sum[QW-1:0];
        if (qv_sum[9])
            q1_next[LANE_V] = '0;
        else if (qv_sum[8:0] > 9'(QFACTOR_MAX))
            q1_next[LANE_V] = QW'(QFACTOR_MAX);
        else
            q1_next[LANE_V] = qv_sum[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            q1_reg <= q1_next;
            h1_reg <= h1_next;
        end
    end

    // stage 2: table position and DC scale
    logic [POS_W-1:0]   pos2_reg [LANES];
    logic [SCALE_W-1:0] scale2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            for (int l = 0; l < LANES; l++)
                pos2_reg[l] <= pos_lut[q1_reg[l]];
            scale2_reg <= scale_lut[h1_reg];
        end
    end

    // stage 3: fetch neighboring table entries
    logic [STEP_W-1:0]    t0_3_reg  [LANES];
    logic [STEP_W-1:0]    t1_3_reg  [LANES];
    logic [FRAC_BITS-1:0] eps3_reg  [LANES];
    logic [SCALE_W-1:0]   scale3_reg;
    logic [IDX_W-1:0]     idx2      [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            idx2[l] = IDX_W'(pos2_reg[l][POS_W-1:FRAC_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                t0_3_reg[l] <= table_at(idx2[l], min_step_reg, max_step_reg);
                t1_3_reg[l] <= table_at(idx2[l] + IDX_W'(1), min_step_reg, max_step_reg);
                eps3_reg[l] <= pos2_reg[l][FRAC_BITS-1:0];
            end
            scale3_reg <= scale2_reg;
        end
    end

    // stage 4: linear interpolation with rounding
    logic [STEP_W-1:0]  val4_reg  [LANES];
    logic [STEP_W-1:0]  val4_next [LANES];
    logic [SCALE_W-1:0] scale4_reg;
    logic [20:0]        interp    [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            interp[l] = 21'(t0_3_reg[l]) * 21'(5'(FRAC_STEPS) - 5'(eps3_reg[l]))
                      + 21'(t1_3_reg[l]) * 21'(eps3_reg[l])
                      + 21'(FRAC_STEPS / 2);
            val4_next[l] = interp[l][STEP_W+FRAC_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            val4_reg   <= val4_next;
            scale4_reg <= scale3_reg;
        end
    end

    // stage 5: DC scale multiply, clamp the unscaled steps
    logic [STEP_W-1:0]         luma5_reg;
    logic [STEP_W-1:0]         u_ac5_reg;
    logic [STEP_W-1:0]         v_ac5_reg;
    logic [STEP_W+SCALE_W-1:0] u_prod5_reg;
    logic [STEP_W+SCALE_W-1:0] v_prod5_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            luma5_reg   <= clamp_step({1'b0, val4_reg[LANE_Y]}, min_step_reg, max_step_reg);
            u_ac5_reg   <= clamp_step({1'b0, val4_reg[LANE_U]}, min_step_reg, max_step_reg);
            v_ac5_reg   <= clamp_step({1'b0, val4_reg[LANE_V]}, min_step_reg, max_step_reg);
            u_prod5_reg <= (STEP_W+SCALE_W)'(val4_reg[LANE_U]) * (STEP_W+SCALE_W)'(scale4_reg);
            v_prod5_reg <= (STEP_W+SCALE_W)'(val4_reg[LANE_V]) * (STEP_W+SCALE_W)'(scale4_reg);
        end
    end

    // stage 6: round the scaled DC steps and clamp; output register
    logic [STEP_W+SCALE_W:0] u_round;
    logic [STEP_W+SCALE_W:0] v_round;
    logic [STEP_W-1:0]       luma6_reg;
    logic [STEP_W-1:0]       u_dc6_reg;
    logic [STEP_W-1:0]       u_ac6_reg;
    logic [STEP_W-1:0]       v_dc6_reg;
    logic [STEP_W-1:0]       v_ac6_reg;

    assign u_round = (STEP_W+SCALE_W+1)'(u_prod5_reg) + (STEP_W+SCALE_W+1)'(32768);
    assign v_round = (STEP_W+SCALE_W+1)'(v_prod5_reg) + (STEP_W+SCALE_W+1)'(32768);

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            luma6_reg <= luma5_reg;
            u_ac6_reg <= u_ac5_reg;
            v_ac6_reg <= v_ac5_reg;
            u_dc6_reg <= clamp_step(u_round[STEP_W+SCALE_W:SCALE_W], min_step_reg,
                                    max_step_reg);
            v_dc6_reg <= clamp_step(v_round[STEP_W+SCALE_W:SCALE_W], min_step_reg,
                                    max_step_reg);
        end
    end

    assign rsp.valid      = valid_reg[STAGES];
    assign rsp.luma_step  = luma6_reg;
    assign rsp.u_dc_step  = u_dc6_reg;
    assign rsp.u_ac_step  = u_ac6_reg;
    assign rsp.v_dc_step  = v_dc6_reg;
    assign rsp.v_ac_step  = v_ac6_reg;
    assign rsp.alpha_step = luma6_reg;

`ifndef SYNTH
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> &valid_reg)
        else $error("request stalled with an empty stage");

    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (q1_reg[LANE_Y] <= QW'(QFACTOR_MAX))
                      && (q1_reg[LANE_U] <= QW'(QFACTOR_MAX))
                      && (q1_reg[LANE_V] <= QW'(QFACTOR_MAX))
                      && (h1_reg <= HW'(HINT_MAX)))
        else $error("quality value out of range after clamp");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> ((pos2_reg[LANE_Y][FRAC_BITS-1:0] == '0)
                          || (idx2[LANE_Y] < IDX_W'(TABLE_STEPS)))
                      && ((pos2_reg[LANE_U][FRAC_BITS-1:0] == '0)
                          || (idx2[LANE_U] < IDX_W'(TABLE_STEPS)))
                      && ((pos2_reg[LANE_V][FRAC_BITS-1:0] == '0)
                          || (idx2[LANE_V] < IDX_W'(TABLE_STEPS))))
        else $error("interpolation past last table entry");
`endif

endmodule

`default_nettype wire
